### sv/mi3_pkg.sv
`timescale 1ns / 1ps
package mi3_pkg;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int COF_W       = PROD_W + 1;
   localparam int DP_W        = ELEM_W + COF_W;
   localparam int DET_W       = DP_W + 2;
   localparam int OUT_W       = 32;
   localparam int FRAC_IN     = 8;
   localparam int FRAC_OUT    = 16;
   localparam int NUM_SHIFT   = FRAC_IN + FRAC_OUT;
   localparam int NUM_W       = COF_W + NUM_SHIFT;
   localparam int QUO_W       = OUT_W + 1;
   localparam int DIV_W       = DET_W + QUO_W - 1;
   localparam int N_ELEM      = 9;
   localparam int FRONT_STAGES = 4;
   localparam int DIV_STAGES  = QUO_W + 2;
   localparam int TOTAL_STAGES = FRONT_STAGES + DIV_STAGES + 1;

   localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic signed [DET_W-1:0]  det_type;
   typedef logic [OUT_W-1:0]         res_type;

   typedef struct packed {
      logic                          singular;
      logic [N_ELEM-1:0][ELEM_W-1:0] elems;
   } side_type;

   // cofactor k = x[PA]*x[PB] - x[NA]*x[NB]
   localparam logic [3:0] PA [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam logic [3:0] PB [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam logic [3:0] NA [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam logic [3:0] NB [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
endpackage

### sv/mi3_front.sv
`timescale 1ns / 1ps
module mi3_front import mi3_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  elem_type x_in [N_ELEM],
   output elem_type x_out [N_ELEM],
   output cof_type  cof_out [N_ELEM],
   output det_type  det_out
);
   logic signed [PROD_W-1:0] pp_ff [N_ELEM];
   logic signed [PROD_W-1:0] pn_ff [N_ELEM];
   elem_type x1_ff [N_ELEM];
   elem_type x2_ff [N_ELEM];
   elem_type x3_ff [N_ELEM];
   elem_type x4_ff [N_ELEM];
   cof_type  cof2_ff [N_ELEM];
   cof_type  cof3_ff [N_ELEM];
   cof_type  cof4_ff [N_ELEM];
   logic signed [DP_W-1:0] dp_ff [3];
   det_type det_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N_ELEM; k++) begin
            pp_ff[k]   <= x_in[PA[k]] * x_in[PB[k]];
            pn_ff[k]   <= x_in[NA[k]] * x_in[NB[k]];
            x1_ff[k]   <= x_in[k];
            cof2_ff[k] <= COF_W'(pp_ff[k]) - COF_W'(pn_ff[k]);
            x2_ff[k]   <= x1_ff[k];
            cof3_ff[k] <= cof2_ff[k];
            x3_ff[k]   <= x2_ff[k];
            cof4_ff[k] <= cof3_ff[k];
            x4_ff[k]   <= x3_ff[k];
         end
         for (int j = 0; j < 3; j++) begin
            dp_ff[j] <= DP_W'(x2_ff[j]) * DP_W'(cof2_ff[3*j]);
         end
         det_ff <= DET_W'(dp_ff[0]) + DET_W'(dp_ff[1]) + DET_W'(dp_ff[2]);
      end
   end

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         x_out[k]   = x4_ff[k];
         cof_out[k] = cof4_ff[k];
      end
      det_out = det_ff;
   end
endmodule

### sv/mi3_div_lane.sv
`timescale 1ns / 1ps
module mi3_div_lane import mi3_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  cof_type cof,
   input  det_type det,
   output res_type quo
);
   logic [NUM_W-1:0]   r_ff    [QUO_W+1];
   logic [DET_W-1:0]   d_ff    [QUO_W+1];
   logic [QUO_W-1:0]   q_ff    [QUO_W+1];
   logic               sign_ff [QUO_W+1];
   logic               ovf_ff  [QUO_W+1];
   res_type            quo_ff;

   logic signed [NUM_W:0] num;
   logic [NUM_W:0]        nabs;
   logic [DET_W:0]        dabs;
   logic [NUM_W-1:0]      nmag;
   logic [DET_W-1:0]      dmag;

   always_comb begin
      num  = {cof[COF_W-1], cof, {NUM_SHIFT{1'b0}}};
      nabs = num[NUM_W] ? -num : num;
      dabs = det[DET_W-1] ? -{det[DET_W-1], det} : {det[DET_W-1], det};
      nmag = nabs[NUM_W-1:0];
      dmag = dabs[DET_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= nmag;
         d_ff[0]    <= dmag;
         q_ff[0]    <= '0;
         sign_ff[0] <= cof[COF_W-1] ^ det[DET_W-1];
         ovf_ff[0]  <= DIV_W'(nmag) >= {dmag, {(QUO_W-1){1'b0}}};
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [DIV_W-1:0] dsh;
      logic             take;
      always_comb begin
         dsh  = DIV_W'(d_ff[k]) << (QUO_W - 1 - k);
         take = DIV_W'(r_ff[k]) >= dsh;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]    <= take ? NUM_W'(DIV_W'(r_ff[k]) - dsh) : r_ff[k];
            q_ff[k+1]    <= q_ff[k] | (QUO_W'(take) << (QUO_W - 1 - k));
            d_ff[k+1]    <= d_ff[k];
            sign_ff[k+1] <= sign_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
         end
      end
   end

   logic [QUO_W-1:0] q;
   logic [QUO_W-1:0] qneg;
   res_type          sat;
   always_comb begin
      q    = q_ff[QUO_W];
      qneg = -q;
      if (ovf_ff[QUO_W]) begin
         sat = sign_ff[QUO_W] ? SAT_MIN : SAT_MAX;
      end else if (!sign_ff[QUO_W]) begin
         sat = (q > QUO_W'(SAT_MAX)) ? SAT_MAX : q[OUT_W-1:0];
      end else begin
         sat = (q > QUO_W'(SAT_MIN)) ? SAT_MIN : qneg[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= sat;
      end
   end

   assign quo = quo_ff;
endmodule

### sv/mi3_merge.sv
`timescale 1ns / 1ps
module mi3_merge import mi3_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  side_type side,
   input  res_type  quo [N_ELEM],
   output res_type  res [N_ELEM],
   output logic     singular
);
   res_type res_ff [N_ELEM];
   logic    sing_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= side.singular;
         for (int k = 0; k < N_ELEM; k++) begin
            // widen q8.8 to q16.16
            res_ff[k] <= side.singular
               ? {{(OUT_W-ELEM_W-(FRAC_OUT-FRAC_IN)){side.elems[k][ELEM_W-1]}},
                  side.elems[k], {(FRAC_OUT-FRAC_IN){1'b0}}}
               : quo[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         res[k] = res_ff[k];
      end
      singular = sing_ff;
   end
endmodule

### sv/matrix3_inverse.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate method. Takes one matrix of signed q8.8 elements
// per cycle unless the output stalls, and returns the inverse as signed q16.16, each element
// the cofactor shifted left 24 and divided by the determinant, truncated toward zero and
// saturated to 32 bits. A zero determinant returns the input widened to q16.16 with
// rsp_singular set. Sustained rate is one request per cycle while the output is not stalled.
// The pipeline runs through the cofactor and determinant products, the nine parallel
// pipelined restoring dividers (one quotient bit per stage) and the output register. A
// stalled output holds the whole pipeline.
module matrix3_inverse import mi3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_in_r1c1,
   input  logic [15:0] req_in_r1c2,
   input  logic [15:0] req_in_r1c3,
   input  logic [15:0] req_in_r2c1,
   input  logic [15:0] req_in_r2c2,
   input  logic [15:0] req_in_r2c3,
   input  logic [15:0] req_in_r3c1,
   input  logic [15:0] req_in_r3c2,
   input  logic [15:0] req_in_r3c3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_inv_r1c1,
   output logic [31:0] rsp_inv_r1c2,
   output logic [31:0] rsp_inv_r1c3,
   output logic [31:0] rsp_inv_r2c1,
   output logic [31:0] rsp_inv_r2c2,
   output logic [31:0] rsp_inv_r2c3,
   output logic [31:0] rsp_inv_r3c1,
   output logic [31:0] rsp_inv_r3c2,
   output logic [31:0] rsp_inv_r3c3,
   output logic        rsp_singular
);
   logic [TOTAL_STAGES-1:0] vld_ff;
   logic [TOTAL_STAGES-1:0] vld_in;
   logic                    en;
   elem_type x_in  [N_ELEM];
   elem_type x_f   [N_ELEM];
   cof_type  cof_f [N_ELEM];
   det_type  det_f;
   res_type  quo   [N_ELEM];
   res_type  res   [N_ELEM];
   side_type side_ff [DIV_STAGES];
   side_type side_in;

   assign en        = !vld_ff[TOTAL_STAGES-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[TOTAL_STAGES-1];

   always_comb begin
      x_in[0] = req_in_r1c1;
      x_in[1] = req_in_r1c2;
      x_in[2] = req_in_r1c3;
      x_in[3] = req_in_r2c1;
      x_in[4] = req_in_r2c2;
      x_in[5] = req_in_r2c3;
      x_in[6] = req_in_r3c1;
      x_in[7] = req_in_r3c2;
      x_in[8] = req_in_r3c3;
      vld_in  = {vld_ff[TOTAL_STAGES-2:0], req_valid};
      side_in.singular = (det_f == '0);
      for (int k = 0; k < N_ELEM; k++) begin
         side_in.elems[k] = x_f[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < DIV_STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   mi3_front u_front (
      .clock   (clock),
      .en      (en),
      .x_in    (x_in),
      .x_out   (x_f),
      .cof_out (cof_f),
      .det_out (det_f)
   );

   for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
      mi3_div_lane u_lane (
         .clock (clock),
         .en    (en),
         .cof   (cof_f[k]),
         .det   (det_f),
         .quo   (quo[k])
      );
   end

   mi3_merge u_merge (
      .clock    (clock),
      .en       (en),
      .side     (side_ff[DIV_STAGES-1]),
      .quo      (quo),
      .res      (res),
      .singular (rsp_singular)
   );

   assign rsp_inv_r1c1 = res[0];
   assign rsp_inv_r1c2 = res[1];
   assign rsp_inv_r1c3 = res[2];
   assign rsp_inv_r2c1 = res[3];
   assign rsp_inv_r2c2 = res[4];
   assign rsp_inv_r2c3 = res[5];
   assign rsp_inv_r3c1 = res[6];
   assign rsp_inv_r3c2 = res[7];
   assign rsp_inv_r3c3 = res[8];
endmodule

### sv/mi3_checker.sv
`timescale 1ns / 1ps
module mi3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_inv_r1c1,
   input logic [31:0] rsp_inv_r3c3,
   input logic        rsp_singular
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inv_r1c1) && $stable(rsp_singular))
      else $error("stalled response changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   a_widen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_inv_r3c3[7:0] == 8'h00
         && (rsp_inv_r3c3[31:23] == 9'h000 || rsp_inv_r3c3[31:23] == 9'h1ff))
      else $error("singular passthrough not widened");
endmodule

bind matrix3_inverse mi3_checker u_mi3_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_inv_r1c1 (rsp_inv_r1c1),
   .rsp_inv_r3c3 (rsp_inv_r3c3),
   .rsp_singular (rsp_singular)
);

### tb/matrix3_inverse_tb.sv
`timescale 1ns / 1ps
module matrix3_inverse_tb;
   import mi3_pkg::*;

   typedef struct {
      logic [31:0] inv [9];
      logic        singular;
   } inverse_type;

   typedef struct {
      logic [15:0] m [9];
      logic        has_known;
      inverse_type known;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_m [9];
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_inv [9];
   logic        rsp_singular;

   inverse_type pending_inverses [$];
   int          fail_count;
   int          matrices_sent;
   int          inverses_checked;
   int          singular_seen;
   int          saturated_seen;
   bit          calm_tail;
   bit          long_hold;
   bit          stimulus_done;

   matrix3_inverse uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_r1c1(req_m[0]), .req_in_r1c2(req_m[1]), .req_in_r1c3(req_m[2]),
      .req_in_r2c1(req_m[3]), .req_in_r2c2(req_m[4]), .req_in_r2c3(req_m[5]),
      .req_in_r3c1(req_m[6]), .req_in_r3c2(req_m[7]), .req_in_r3c3(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_inv_r1c1(rsp_inv[0]), .rsp_inv_r1c2(rsp_inv[1]), .rsp_inv_r1c3(rsp_inv[2]),
      .rsp_inv_r2c1(rsp_inv[3]), .rsp_inv_r2c2(rsp_inv[4]), .rsp_inv_r2c3(rsp_inv[5]),
      .rsp_inv_r3c1(rsp_inv[6]), .rsp_inv_r3c2(rsp_inv[7]), .rsp_inv_r3c3(rsp_inv[8]),
      .rsp_singular(rsp_singular)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [31:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7fff_ffff;
      if (v < -128'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic inverse_type invert_matrix(input logic [15:0] m [9]);
      inverse_type r;
      logic signed [127:0] x [9];
      logic signed [127:0] adj [9];
      logic signed [127:0] det;
      for (int k = 0; k < 9; k++) x[k] = $signed(m[k]);
      adj[0] = x[4] * x[8] - x[5] * x[7];
      adj[1] = x[2] * x[7] - x[1] * x[8];
      adj[2] = x[1] * x[5] - x[2] * x[4];
      adj[3] = x[5] * x[6] - x[3] * x[8];
      adj[4] = x[0] * x[8] - x[2] * x[6];
      adj[5] = x[2] * x[3] - x[0] * x[5];
      adj[6] = x[3] * x[7] - x[4] * x[6];
      adj[7] = x[1] * x[6] - x[0] * x[7];
      adj[8] = x[0] * x[4] - x[1] * x[3];
      det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
      r.singular = (det == 0);
      for (int k = 0; k < 9; k++)
         r.inv[k] = r.singular ? clamp32(x[k] <<< 8) : clamp32((adj[k] <<< 24) / det);
      return r;
   endfunction

   // receiver: random stalls, one long hold, none in the tail
   initial begin
      int gap;
      rsp_ready = 1'b0;
      long_hold = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      inverse_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_inverses.size() == 0) begin
            $error("unexpected inverse");
            fail_count++;
         end else begin
            want = pending_inverses.pop_front();
            for (int k = 0; k < 9; k++)
               if (rsp_inv[k] !== want.inv[k]) begin
                  $error("inv_r%0dc%0d expected %h actual %h", k / 3 + 1, k % 3 + 1,
                         want.inv[k], rsp_inv[k]);
                  fail_count++;
               end
            if (rsp_singular !== want.singular) begin
               $error("singular expected %b actual %b", want.singular, rsp_singular);
               fail_count++;
            end
            if (want.singular) singular_seen++;
            foreach (want.inv[k])
               if (want.inv[k] == 32'h7fff_ffff || want.inv[k] == 32'h8000_0000)
                  saturated_seen++;
            inverses_checked++;
         end
      end
   end

   task automatic send_matrix(input row_type row);
      inverse_type want;
      want = row.has_known ? row.known : invert_matrix(row.m);
      req_valid <= 1'b1;
      for (int k = 0; k < 9; k++) req_m[k] <= row.m[k];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_inverses.push_back(want);
      matrices_sent++;
   endtask

   task automatic idle_sender();
      int gap;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic row_type diag_row(input logic [15:0] d0, d1, d2);
      row_type r;
      foreach (r.m[k]) r.m[k] = 16'h0000;
      r.m[0] = d0; r.m[4] = d1; r.m[8] = d2;
      r.has_known = 1'b0;
      return r;
   endfunction

   function automatic row_type fill_row(input logic [15:0] v);
      row_type r;
      foreach (r.m[k]) r.m[k] = v;
      r.has_known = 1'b0;
      return r;
   endfunction

   function automatic row_type random_row();
      row_type r;
      int mode;
      mode = $urandom_range(0, 9);
      r.has_known = 1'b0;
      foreach (r.m[k]) begin
         case (mode)
            0, 1, 2: r.m[k] = 16'($urandom);
            3, 4:    r.m[k] = 16'($urandom_range(0, 15) - 8);
            5:       r.m[k] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: r.m[k] = 16'($urandom_range(0, 1023) - 512);
         endcase
      end
      if (mode == 6) begin
         // force a dependent row so the determinant is zero
         for (int c = 0; c < 3; c++) r.m[6 + c] = r.m[c] + r.m[3 + c];
         if (invert_matrix(r.m).singular == 1'b0)
            for (int c = 0; c < 3; c++) r.m[6 + c] = r.m[c];
      end
      return r;
   endfunction

   initial begin
      row_type table_rows [$];
      row_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      foreach (req_m[k]) req_m[k] = 16'h0000;
      fail_count = 0;
      matrices_sent = 0;
      inverses_checked = 0;
      singular_seen = 0;
      saturated_seen = 0;
      calm_tail = 1'b0;
      stimulus_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // all zero: singular, passed through
      r = fill_row(16'h0000);
      r.has_known = 1'b1;
      r.known.singular = 1'b1;
      foreach (r.known.inv[k]) r.known.inv[k] = 32'h0;
      table_rows.push_back(r);
      // identity: inverse is 1.0 on the diagonal
      r = diag_row(16'h0100, 16'h0100, 16'h0100);
      r.has_known = 1'b1;
      r.known.singular = 1'b0;
      foreach (r.known.inv[k]) r.known.inv[k] = (k % 4 == 0) ? 32'h0001_0000 : 32'h0;
      table_rows.push_back(r);
      // all max: singular, widened
      r = fill_row(16'h7fff);
      r.has_known = 1'b1;
      r.known.singular = 1'b1;
      foreach (r.known.inv[k]) r.known.inv[k] = 32'h007f_ff00;
      table_rows.push_back(r);
      // all min: singular, widened
      r = fill_row(16'h8000);
      r.has_known = 1'b1;
      r.known.singular = 1'b1;
      foreach (r.known.inv[k]) r.known.inv[k] = 32'hff80_0000;
      table_rows.push_back(r);
      // tiny diagonal: large quotients of both signs
      table_rows.push_back(diag_row(16'h0001, 16'h0001, 16'h0001));
      table_rows.push_back(diag_row(16'hffff, 16'h0001, 16'h0001));
      table_rows.push_back(diag_row(16'h0001, 16'hffff, 16'hffff));
      table_rows.push_back(diag_row(16'h7fff, 16'h7fff, 16'h7fff));
      table_rows.push_back(diag_row(16'h8000, 16'h8000, 16'h8000));
      table_rows.push_back(diag_row(16'h8000, 16'h7fff, 16'h0001));
      table_rows.push_back(diag_row(16'h0200, 16'hfe00, 16'h0080));
      r = fill_row(16'h5555); r.m[4] = 16'haaaa; table_rows.push_back(r);
      r = fill_row(16'haaaa); r.m[0] = 16'h5555; r.m[8] = 16'h0f0f; table_rows.push_back(r);
      r = fill_row(16'hffff); r.m[1] = 16'h0000; r.m[5] = 16'h0000; table_rows.push_back(r);
      foreach (table_rows[n]) begin
         send_matrix(table_rows[n]);
         idle_sender();
      end

      for (int n = 0; n < 1600; n++) begin
         if (n == 300) long_hold = 1'b1;
         if (n == 1400) calm_tail = 1'b1;
         send_matrix(random_row());
         idle_sender();
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;

      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("sent %0d matrices, checked %0d inverses", matrices_sent, inverses_checked);
      $display("%0d singular, %0d saturated elements", singular_seen, saturated_seen);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
